/* rtl/tcc_pkg.sv */
// Shared constants, types and helpers for the ternary code correlator.
// No dependencies; every other file of the block imports this package.
package tcc_pkg;

	// Number of code taps; the correlator row holds TAPS-1 partial-sum cells.
	localparam int TAPS     = 128;
	localparam int SAMPLE_W = 16;
	localparam int CORR_W   = 24;

	// Control that goes to every cell of the row.
	typedef struct packed {
		logic en;   // an item is accepted this cycle
		logic clr;  // the item starts a new record
	} cell_ctl_t;

	// Code weight of tap k: -1 where k mod 3 is 0, +1 otherwise.
	function automatic logic code_neg(input int k);
		return (k % 3) == 0;
	endfunction

endpackage

/* rtl/tcc_if.sv */
// Channel interfaces for the correlator: sample items in, result items out.
// Depends on tcc_pkg for the field widths.
interface tcc_sample_if;
	import tcc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface tcc_result_if;
	import tcc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CORR_W-1:0] correlation;

	modport source (output valid, output correlation, input ready);
	modport sink   (input valid, input correlation, output ready);
endinterface

/* rtl/tcc_cell.sv */
// One cell of the transposed correlator row: a partial-sum register and an adder.
// Depends on tcc_pkg.
module tcc_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcc_pkg::cell_ctl_t                ctl,
	input  logic                              neg,
	input  logic signed [tcc_pkg::CORR_W-1:0] x,
	input  logic signed [tcc_pkg::CORR_W-1:0] psum_in,
	output logic signed [tcc_pkg::CORR_W-1:0] psum_q
);
	import tcc_pkg::*;

	logic signed [CORR_W-1:0] addend;
	logic signed [CORR_W-1:0] carried;
	logic signed [CORR_W-1:0] sum;

	// A restart drops what the neighbor carries, so earlier samples count as zero.
	assign addend  = neg ? -x : x;
	assign carried = ctl.clr ? '0 : psum_in;
	assign sum     = carried + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (ctl.en) begin
			psum_q <= sum;
		end
	end
endmodule

/* rtl/tcc_chain.sv */
// Row of TAPS-1 correlator cells; partial sums move from the far end toward tap 1.
// Depends on tcc_pkg and tcc_cell.
module tcc_chain (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcc_pkg::cell_ctl_t                ctl,
	input  logic signed [tcc_pkg::CORR_W-1:0] x,
	output logic signed [tcc_pkg::CORR_W-1:0] psum_head
);
	import tcc_pkg::*;

	// psum[k] is the register of the cell for tap k; psum[TAPS] is the zero end.
	logic signed [CORR_W-1:0] psum [1:TAPS];

	assign psum[TAPS] = '0;

	for (genvar k = 1; k < TAPS; k++) begin : g_cell
		tcc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.neg     (code_neg(k)),
			.x       (x),
			.psum_in (psum[k+1]),
			.psum_q  (psum[k])
		);
	end

	assign psum_head = psum[1];
endmodule

/* rtl/ternary_code_correlator.sv */
// Streaming matched filter against a fixed ternary code, built as a transposed FIR.
// Depends on tcc_pkg, tcc_if and tcc_chain.
//
// The correlator takes one signed 16-bit sample item per clock and returns one
// 24-bit correlation item for each, y[n] = sum of code(k)*x[n-k] over k from 0 to
// TAPS-1, where code(k) is -1 when k mod 3 is 0 and +1 otherwise. The filter is a
// row of TAPS-1 cells, each holding the partial sum that a later output still
// needs; every accepted sample is broadcast to all cells, each cell adds or
// subtracts it and hands its sum to the neighbor nearer the output. The result of
// a sample is its own tap-0 term added to the head of the row, and it appears in
// the output register on the cycle after the sample is accepted. The sustained
// rate is one item per cycle, limited only by the single 24-bit add in each cell
// and the output register; a new sample is taken whenever the output register is
// empty or its item is taken in the same cycle. A sample with restart set starts a
// new record: all partial sums are dropped in that same cycle, so no clearing pass
// is needed and earlier samples count as zero. Sums wrap modulo 2^24, which is
// exact for the default TAPS. Feed TAPS-1 zero samples to flush the tail.
module ternary_code_correlator (
	input  logic           clk,
	input  logic           arst_n,
	tcc_sample_if.sink     samples,
	tcc_result_if.source   results
);
	import tcc_pkg::*;

	cell_ctl_t                ctl;
	logic                     accept;
	logic signed [CORR_W-1:0] x;
	logic signed [CORR_W-1:0] psum_head;
	logic signed [CORR_W-1:0] head;
	logic signed [CORR_W-1:0] corr_q;
	logic                     out_valid_q;

	// The output register frees up when it is empty or being drained.
	assign samples.ready = !out_valid_q || results.ready;
	assign accept        = samples.valid && samples.ready;

	assign ctl.en  = accept;
	assign ctl.clr = samples.restart;

	// Sign-extend the sample to the width of the running sums.
	assign x = {{(CORR_W - SAMPLE_W){samples.sample[SAMPLE_W-1]}}, samples.sample};

	tcc_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.x         (x),
		.psum_head (psum_head)
	);

	// Tap 0 is the current sample itself; a restart leaves it alone in the sum.
	always_comb begin
		head = samples.restart ? '0 : psum_head;
		if (code_neg(0)) begin
			head = head - x;
		end else begin
			head = head + x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			corr_q <= head;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.correlation = corr_q;
endmodule

/* rtl/tcc_checker.sv */
// Port-level checks for the ternary code correlator, bound to the top level.
// Depends on tcc_pkg and ternary_code_correlator.
module tcc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic signed [tcc_pkg::SAMPLE_W-1:0] in_sample,
	input logic                              in_restart,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [tcc_pkg::CORR_W-1:0] out_correlation
);
	import tcc_pkg::*;

	logic signed [CORR_W-1:0] in_ext;

	assign in_ext = {{(CORR_W - SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};

	// A stalled result item stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_correlation))
		else $error("result item changed while stalled");

	// Every accepted sample shows its result on the next cycle.
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after an accepted sample");

	// No sample is taken while the held result is not being drained.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("sample accepted over a pending result");

	// A restart sample correlates only with itself, weighted by minus one.
	a_restart_value: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_restart |=> out_correlation == -$past(in_ext))
		else $error("restart result is not the negated sample");
endmodule

bind ternary_code_correlator tcc_checker u_tcc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (samples.valid),
	.in_ready        (samples.ready),
	.in_sample       (samples.sample),
	.in_restart      (samples.restart),
	.out_valid       (results.valid),
	.out_ready       (results.ready),
	.out_correlation (results.correlation)
);
